>>> hw/rtl/grbp_pkg.sv
package grbp_pkg;

  // Byte and code geometry
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;    // pending bit count, 0..7
  localparam int KEEP_W = 7;    // leftover bits held between items
  localparam int K_W    = 4;    // Rice parameter width
  localparam int REM_W  = 16;   // left-aligned remainder shifter, k up to 15

  // Queue occupancy seen by the front and back
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_status_t;

endpackage

>>> hw/rtl/grbp_if.sv
interface grbp_item_if #(
  parameter int ERROR_WIDTH = 9
);
  logic                   valid;
  logic                   ready;
  logic [ERROR_WIDTH-1:0] error_value;
  logic [3:0]             rice_k;

  modport source (output valid, output error_value, output rice_k, input ready);
  modport sink   (input valid, input error_value, input rice_k, output ready);
endinterface

interface grbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/grbp_front.sv
module grbp_front
  import grbp_pkg::*;
#(
  parameter int ERROR_WIDTH = 9
) (
  grbp_item_if.sink              item,
  input  q_status_t              status,
  output logic                   push,
  output logic [REM_W-1:0]       rem_sh,
  output logic [K_W-1:0]         rem_len,
  output logic [ERROR_WIDTH-1:0] zeros
);

  logic [REM_W-1:0] value_ext;
  logic [REM_W-1:0] rem_mask;
  logic [4:0]       align;

  assign item.ready = status.not_full;
  assign push       = item.valid && status.not_full;

  // Remainder goes MSB-first, so park it at the top of the shifter
  always_comb begin
    value_ext = REM_W'(item.error_value);
    rem_mask  = (REM_W'(1) << item.rice_k) - REM_W'(1);
    align     = 5'(REM_W) - {1'b0, item.rice_k};
    rem_sh    = (value_ext & rem_mask) << align;
    rem_len   = item.rice_k;
    zeros     = item.error_value >> item.rice_k;
  end

endmodule

>>> hw/rtl/grbp_queue.sv
module grbp_queue
  import grbp_pkg::*;
#(
  parameter int WIDTH = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output q_status_t        status
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign dout             = mem[rd_ptr];
  assign status.not_full  = (count != 2'd2);
  assign status.not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/grbp_back.sv
module grbp_back
  import grbp_pkg::*;
#(
  parameter int ERROR_WIDTH = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  q_status_t              status,
  input  logic [REM_W-1:0]       head_rem,
  input  logic [K_W-1:0]         head_r,
  input  logic [ERROR_WIDTH-1:0] head_z,
  output logic                   pop,
  grbp_byte_if.source            code
);

  localparam int TW = ERROR_WIDTH + 1;

  logic                   busy;
  logic [REM_W-1:0]       w_rem;
  logic [K_W-1:0]         w_r;
  logic [ERROR_WIDTH-1:0] w_z;
  logic [KEEP_W-1:0]      pending;
  logic [CNT_W-1:0]       cnt;

  logic [REM_W-1:0]       cur_rem;
  logic [K_W-1:0]         cur_r;
  logic [ERROR_WIDTH-1:0] cur_z;
  logic                   active;
  logic                   step;
  logic [TW-1:0]          rz;
  logic [TW-1:0]          total;
  logic [3:0]             avail;
  logic [3:0]             room;
  logic [3:0]             take;
  logic [7:0]             chunk;
  logic [15:0]            merged;
  logic [3:0]             fill;
  logic                   emit;
  logic [3:0]             dr;
  logic [3:0]             dz;
  logic                   done;
  logic                   last;
  logic [REM_W-1:0]       rem_next;
  logic [K_W-1:0]         r_next;
  logic [ERROR_WIDTH-1:0] z_next;

  always_comb begin
    cur_rem = busy ? w_rem : head_rem;
    cur_r   = busy ? w_r   : head_r;
    cur_z   = busy ? w_z   : head_z;
    active  = busy || status.not_empty;
    step    = active && (!code.valid || code.ready);

    // Remaining code length: remainder bits, zeros, terminating one
    rz    = TW'(cur_r) + TW'(cur_z);
    total = rz + TW'(1);
    avail = (total >= TW'(8)) ? 4'd8 : total[3:0];
    room  = 4'd8 - {1'b0, cnt};
    take  = (avail < room) ? avail : room;

    // Next eight code bits, MSB first
    chunk = cur_rem[REM_W-1 -: 8] & ~(8'hFF >> cur_r);
    if (rz < TW'(8)) begin
      chunk = chunk | (8'h80 >> rz[2:0]);
    end

    merged = (16'({1'b0, pending}) << take) | 16'(chunk >> (4'd8 - take));
    fill   = {1'b0, cnt} + take;
    emit   = fill[3];

    dr       = (4'(cur_r) < take) ? 4'(cur_r) : take;
    dz       = take - dr;
    rem_next = cur_rem << dr;
    r_next   = cur_r - K_W'(dr);
    z_next   = (ERROR_WIDTH'(dz) > cur_z) ? '0 : cur_z - ERROR_WIDTH'(dz);
    done     = (TW'(take) == total);
    last     = ((total - TW'(take)) < TW'(8));

    pop = step && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pending    <= '0;
      cnt        <= '0;
      code.valid <= 1'b0;
    end else begin
      if (step) begin
        busy <= !done;
        if (emit) begin
          pending <= '0;
          cnt     <= '0;
        end else begin
          pending <= merged[KEEP_W-1:0];
          cnt     <= fill[CNT_W-1:0];
        end
      end
      if (step && emit) begin
        code.valid <= 1'b1;
      end else if (code.ready) begin
        code.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      w_rem <= rem_next;
      w_r   <= r_next;
      w_z   <= z_next;
    end
    if (step && emit) begin
      code.out_byte  <= merged[7:0];
      code.last_byte <= last;
    end
  end

endmodule

>>> hw/rtl/golomb_rice_bit_packer.sv
// Channel | Dir | Modport              | Payload
// item    | in  | grbp_item_if.sink    | error_value[ERROR_WIDTH], rice_k[4]
// code    | out | grbp_byte_if.source  | out_byte[8], last_byte
//
// The back packer works through the code in byte-aligned pieces, one per cycle
// whenever its output register is free, one piece per completed byte plus one
// more when bits are left over. The back starts an item once the item is
// registered in the queue and the back is done with the previous item.
// Reset (rst, synchronous) clears pending bits, the queue and output valid.
// A stall on code holds the packer; the two-entry queue keeps taking items
// until it fills.
module golomb_rice_bit_packer
  import grbp_pkg::*;
#(
  parameter int ERROR_WIDTH = 9
) (
  input  logic        clk,
  input  logic        rst,
  grbp_item_if.sink   item,
  grbp_byte_if.source code
);

  localparam int QW = REM_W + K_W + ERROR_WIDTH;

  q_status_t              status;
  logic                   push;
  logic                   pop;
  logic [REM_W-1:0]       rem_sh;
  logic [K_W-1:0]         rem_len;
  logic [ERROR_WIDTH-1:0] zeros;
  logic [QW-1:0]          q_din;
  logic [QW-1:0]          q_dout;

  // Front: decode value and k into remainder shifter, length and zero run
  grbp_front #(.ERROR_WIDTH(ERROR_WIDTH)) u_front (
    .item    (item),
    .status  (status),
    .push    (push),
    .rem_sh  (rem_sh),
    .rem_len (rem_len),
    .zeros   (zeros)
  );

  assign q_din = {rem_sh, rem_len, zeros};

  // Two-entry queue decouples intake from byte packing
  grbp_queue #(.WIDTH(QW)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (q_din),
    .pop    (pop),
    .dout   (q_dout),
    .status (status)
  );

  // Back: packs code bits into bytes, keeps up to seven leftover bits
  grbp_back #(.ERROR_WIDTH(ERROR_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .head_rem (q_dout[QW-1 -: REM_W]),
    .head_r   (q_dout[ERROR_WIDTH +: K_W]),
    .head_z   (q_dout[ERROR_WIDTH-1:0]),
    .pop      (pop),
    .code     (code)
  );

endmodule

>>> hw/rtl/grbp_checker.sv
module grbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // A stalled transfer keeps valid up
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("code valid dropped while stalled");

  // A stalled transfer keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(last_byte))
    else $error("code payload changed while stalled");

  // Reset leaves no byte waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("code valid after reset");

  // Reset empties the queue, so intake opens
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("item not ready after reset");

endmodule

bind golomb_rice_bit_packer grbp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (code.valid),
  .out_ready (code.ready),
  .out_byte  (code.out_byte),
  .last_byte (code.last_byte)
);

>>> bench/golomb_rice_bit_packer_test.sv
`timescale 1ns / 100ps

// Golomb-Rice bit packer testbench.
// Items go in on the item channel. A scoreboard rebuilds the code bit by bit
// and checks every byte transfer on the code channel in order.
module golomb_rice_bit_packer_test;
  import grbp_pkg::*;

  localparam int ERROR_WIDTH = 9;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS = 30;      // tail of the run with no idling
  localparam int DRAIN_CYCLES = 20;    // settle time once nothing is expected

  // One expected byte transfer on the code channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } code_byte_t;

  // Scoreboard: holds its own copy of the leftover bits and the queue of
  // bytes that still have to come out.
  class packer_scoreboard;
    logic [BYTE_W-1:0] held_bits;    // leftover code bits, oldest highest
    int unsigned       held_count;   // 0..7 between items
    code_byte_t        expected_bytes[$];
    int unsigned       errors;

    function new();
      held_bits  = '0;
      held_count = 0;
      errors     = 0;
    endfunction

    // Shift one code bit in; a full byte moves to the expected queue.
    function void append_code_bit(logic b);
      code_byte_t entry;
      held_bits = {held_bits[BYTE_W-2:0], b};
      held_count++;
      if (held_count == BYTE_W) begin
        entry.data = held_bits;
        entry.last = 1'b0;
        expected_bytes.push_back(entry);
        held_bits  = '0;
        held_count = 0;
      end
    endfunction

    // Accepted item: remainder MSB first, quotient in zeros, then a one.
    function void note_item(logic [ERROR_WIDTH-1:0] value, logic [K_W-1:0] k);
      int unsigned quotient;
      int          queued;
      quotient = 32'(value >> k);
      queued   = expected_bytes.size();
      for (int i = int'(k); i > 0; i--) begin
        // k above the value width just pads with leading zeros
        append_code_bit((i - 1 < ERROR_WIDTH) ? value[i - 1] : 1'b0);
      end
      for (int unsigned i = 0; i < quotient; i++) begin
        append_code_bit(1'b0);
      end
      append_code_bit(1'b1);
      if (expected_bytes.size() > queued) begin
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_byte(logic [BYTE_W-1:0] data, logic last);
      code_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h (last %0b) with nothing expected", data, last));
      end else begin
        want = expected_bytes.pop_front();
        if (data !== want.data) begin
          report($sformatf("out_byte %02h, expected %02h", data, want.data));
        end
        if (last !== want.last) begin
          report($sformatf("last_byte %0b, expected %0b on byte %02h",
                           last, want.last, want.data));
        end
      end
    endtask

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic calm;   // set for the tail of the run: no idling on either side

  grbp_item_if #(.ERROR_WIDTH(ERROR_WIDTH)) item_ch ();
  grbp_byte_if code_ch ();

  packer_scoreboard sb = new();

  golomb_rice_bit_packer #(
    .ERROR_WIDTH(ERROR_WIDTH)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .code (code_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    item_ch.valid       = 1'b0;
    item_ch.error_value = '0;
    item_ch.rice_k      = '0;
    code_ch.ready       = 1'b0;
  end

  // Monitor: both channels sampled at the edge, item noted before the check
  // so the scoreboard is always ahead of the bytes it predicts.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        sb.note_item(item_ch.error_value, item_ch.rice_k);
      end
      if (code_ch.valid && code_ch.ready) begin
        sb.check_byte(code_ch.out_byte, code_ch.last_byte);
      end
    end
  end

  // Code side back pressure: random stall bursts between
  // runs of ready. Stalls stop once the calm tail begins.
  initial begin
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        code_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      code_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Drive one item and hold it until the transfer. Afterward maybe drop
  // valid for an idle burst; with no burst valid stays high for the next item.
  task automatic send_item(input logic [ERROR_WIDTH-1:0] value,
                           input logic [K_W-1:0] k);
    item_ch.valid       <= 1'b1;
    item_ch.error_value <= value;
    item_ch.rice_k      <= k;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    logic [ERROR_WIDTH-1:0] value;
    logic [K_W-1:0]         k;
    int unsigned            quotient;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: shortest codes that complete no byte, then extremes
    for (int i = 0; i < 5; i++) send_item('0, 4'd0);   // single 1 bits
    send_item('0, 4'd0);                 // sixth single 1 bit; the next item completes byte ff
    send_item(9'd1, 4'd1);
    send_item(9'd255, 4'd8);             // remainder only, quotient 0
    send_item(9'd256, 4'd8);             // quotient 1
    send_item(9'd511, 4'd8);
    send_item(9'd511, 4'd0);             // longest run of zeros
    send_item(9'd0, 4'd8);
    send_item(9'h155, 4'd4);
    send_item(9'h0AA, 4'd3);
    // k above eight: whole value as remainder, padded with leading zeros
    send_item(9'd511, 4'd9);
    send_item(9'h0A5, 4'd12);
    send_item(9'd511, 4'd15);
    send_item(9'd0, 4'd15);
    send_item(9'h100, 4'd11);
    send_item(9'd7, 4'd2);               // quotient 1 with pending bits
    send_item(9'd200, 4'd0);
    send_item(9'd1, 4'd0);

    // Random: mostly typical codes with short quotients, plus long runs and
    // k above eight
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          k     = K_W'($urandom_range(9, 15));
          value = ERROR_WIDTH'($urandom());
        end
        1: begin
          k     = K_W'($urandom_range(0, 15));
          value = ERROR_WIDTH'($urandom());
        end
        2: begin
          k     = K_W'($urandom_range(0, 3));
          value = ERROR_WIDTH'($urandom());
        end
        default: begin
          k        = K_W'($urandom_range(0, 8));
          quotient = $urandom_range(0, 5);
          value    = (ERROR_WIDTH'(quotient) << k) | (ERROR_WIDTH'($urandom()) &
                     ((ERROR_WIDTH'(1) << k) - ERROR_WIDTH'(1)));
        end
      endcase
      send_item(value, k);
    end
    item_ch.valid <= 1'b0;
    // Let the monitor note the last transfer before counting what is owed
    @(posedge clk);

    // Wait for every expected byte, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("golomb_rice_bit_packer_test: clean");
    end else begin
      $display("golomb_rice_bit_packer_test: errors");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("golomb_rice_bit_packer_test: errors");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/grbp_pkg.sv
hw/rtl/grbp_if.sv
hw/rtl/grbp_front.sv
hw/rtl/grbp_queue.sv
hw/rtl/grbp_back.sv
hw/rtl/golomb_rice_bit_packer.sv
hw/rtl/grbp_checker.sv
bench/golomb_rice_bit_packer_test.sv
